FILE: rtl/sampled_lru_lfu_eviction_engine_defines.svh
// Assertion macros used by the eviction engine controller.
`ifndef SAMPLED_LRU_LFU_EVICTION_ENGINE_DEFINES_SVH
`define SAMPLED_LRU_LFU_EVICTION_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slle assertion failed");

// Next-cycle implication, checked outside reset.
`define SLLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slle assertion failed");

`endif

FILE: rtl/slle_pkg.sv
// Package with widths, codes, state type and control structs of the eviction engine.
package slle_pkg;

  localparam int unsigned FREQ_W       = 8;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned RAND_W       = 32;
  localparam int unsigned IVL_W        = 32;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned SAMPLE_LIMIT_DEF = 16;
  localparam int unsigned ACC_W        = IVL_W + 4;
  localparam int unsigned MULK_W       = 12;
  localparam int unsigned PROD_W       = RAND_W + MULK_W;
  localparam int unsigned PER_W        = 4;
  localparam int unsigned BIT_W        = 5;

  localparam logic [FREQ_W-1:0] FREQ_MAX        = 8'd255;
  localparam logic [FREQ_W-1:0] LRU_INSERT_FREQ = 8'd1;
  localparam logic [FREQ_W-1:0] LFU_INSERT_FREQ = 8'd5;
  localparam logic [3:0]        LOG_FACTOR      = 4'd10;
  localparam logic [PER_W-1:0]  MAX_PERIODS     = 4'd8;

  typedef enum logic [1:0] {
    POL_LRU    = 2'd0,
    POL_LFU    = 2'd1,
    POL_RANDOM = 2'd2,
    POL_NONE   = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    MODE_TOUCH  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECAY,
    S_MULT,
    S_INC,
    S_MOD_INIT,
    S_MOD_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic decay_step;
    logic mult;
    logic inc;
    logic mod_init;
    logic mod_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic lfu_touch;
    logic decay_on;
    logic decay_more;
    logic random_final;
    logic mod_last;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/slle_in_if.sv
// Input item channel of the eviction engine.
interface slle_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [slle_pkg::FREQ_W-1:0]      frequency;
  logic [slle_pkg::TIME_W-1:0]      last_access;
  logic [slle_pkg::TIME_W-1:0]      now_time;
  logic [slle_pkg::RAND_W-1:0]      random_value;
  logic                             final_element;

  modport source (output valid, mode, frequency, last_access, now_time, random_value,
                  final_element, input ready);
  modport sink   (input valid, mode, frequency, last_access, now_time, random_value,
                  final_element, output ready);
endinterface

FILE: rtl/slle_out_if.sv
// Result item channel of the eviction engine.
interface slle_out_if;
  logic                             valid;
  logic                             ready;
  logic [slle_pkg::FREQ_W-1:0]      new_frequency;
  logic [slle_pkg::TIME_W-1:0]      new_last_access;
  logic                             victim_valid;
  logic [slle_pkg::POS_W-1:0]       victim_index;
  logic                             no_victim;
  logic                             sample_overflow;

  modport source (output valid, new_frequency, new_last_access, victim_valid, victim_index,
                  no_victim, sample_overflow, input ready);
  modport sink   (input valid, new_frequency, new_last_access, victim_valid, victim_index,
                  no_victim, sample_overflow, output ready);
endinterface

FILE: rtl/slle_cfg_if.sv
// Configuration write channel of the eviction engine.
interface slle_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [slle_pkg::CFG_IDX_W-1:0]     index;
  logic [slle_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sampled_lru_lfu_eviction_engine.sv
// Top level of the sampled LRU/LFU eviction metadata engine.
// Channels: in_ch takes touch, insert and sample items; out_ch returns one result per
// item; cfg_ch writes policy_select (index 0) and decay_interval (index 1), always ready.
// All channels transfer on a rising clock edge with valid and ready both high.
// Insert, sample and non-LFU touch items go from EVAL straight to DONE. An LFU touch
// passes through MULT and INC, with decay first through DECAY, which adds the interval
// once per elapsed decay period (at most 8); the increment uses the 32x12 multiplier.
// The final sample item under the random policy passes through MOD_INIT and MOD_STEP,
// the one-bit-per-cycle remainder unit.
// One item is processed at a time, and a new item waits until the last one is finished; the
// next input is taken as soon as the result has moved to the output register, even
// while that result still waits for the receiver.
// When the receiver stalls, the result holds in the output register and a second
// finished result waits inside the engine until the register frees.
// Reset (rst_n low, synchronous) selects LRU, disables decay and clears the search.
module sampled_lru_lfu_eviction_engine #(
  parameter int unsigned SAMPLE_LIMIT = slle_pkg::SAMPLE_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  slle_in_if.sink    in_ch,
  slle_out_if.source out_ch,
  slle_cfg_if.sink   cfg_ch
);
  import slle_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    ctrl_in_ready;

  assign in_ch.ready = ctrl_in_ready;

  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  slle_dp #(
    .SAMPLE_LIMIT (SAMPLE_LIMIT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule

FILE: rtl/slle_ctrl.sv
// Sequencing state machine of the eviction engine.
`include "sampled_lru_lfu_eviction_engine_defines.svh"
module slle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slle_pkg::status_t status,
  output slle_pkg::cmd_t    cmd
);
  import slle_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.lfu_touch) begin
          state_nxt = status.decay_on ? S_DECAY : S_MULT;
        end else if (status.random_final) begin
          state_nxt = S_MOD_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DECAY: begin
        if (status.decay_more) begin
          cmd.decay_step = 1'b1;
        end else begin
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_INC;
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = S_DONE;
      end
      S_MOD_INIT: begin
        cmd.mod_init = 1'b1;
        state_nxt    = S_MOD_STEP;
      end
      S_MOD_STEP: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `SLLE_ASSERT_NEXT(a_accept_to_eval, in_valid && in_ready, state_r == S_EVAL)
  `SLLE_ASSERT_NEXT(a_mod_end, state_r == S_MOD_STEP && status.mod_last, state_r == S_DONE)
  `SLLE_ASSERT_SAME(a_no_overwrite, cmd.out_load, !status.out_busy)

endmodule

FILE: rtl/slle_dp.sv
// Datapath of the eviction engine: configuration, item registers, search state, decay, increment, modulo, output.
module slle_dp #(
  parameter int unsigned SAMPLE_LIMIT = slle_pkg::SAMPLE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  slle_in_if.sink           in_ch,
  slle_out_if.source        out_ch,
  slle_cfg_if.sink          cfg_ch,
  input  slle_pkg::cmd_t    cmd,
  output slle_pkg::status_t status
);
  import slle_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLE_LIMIT + 1);

  // Latched item.
  logic [1:0]        mode_r;
  logic [FREQ_W-1:0] freq_r;
  logic [TIME_W-1:0] last_r, now_r;
  logic [RAND_W-1:0] rnd_r;
  logic              fin_r;

  // Configuration.
  logic [1:0]        policy_r;
  logic [IVL_W-1:0]  interval_r;

  // Search state.
  logic [FREQ_W-1:0] best_f_r;
  logic [TIME_W-1:0] best_t_r;
  logic [POS_W-1:0]  best_pos_r;
  logic              have_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;

  // Decay and increment.
  logic [TIME_W-1:0] diff_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PER_W-1:0]  per_r;
  logic [PROD_W-1:0] prod_r;
  logic [FREQ_W-1:0] fd_r, nf_r;

  // Modulo.
  logic [RAND_W-1:0] div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [BIT_W-1:0]  bit_r;

  logic              out_valid_r;

  logic [FREQ_W-1:0] fd;
  logic [MULK_W-1:0] mul_k;
  logic [CNT_W:0]    rem_sh;
  logic              take;
  logic              lfu_tie;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= POL_LRU;
      interval_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_POLICY) begin
        policy_r <= cfg_ch.data[1:0];
      end else if (cfg_ch.index == REG_DECAY) begin
        interval_r <= cfg_ch.data[IVL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_ch.mode;
      freq_r <= in_ch.frequency;
      last_r <= in_ch.last_access;
      now_r  <= in_ch.now_time;
      rnd_r  <= in_ch.random_value;
      fin_r  <= in_ch.final_element;
    end
  end

  assign lfu_tie = (freq_r == best_f_r) && (last_r < best_t_r);

  always_comb begin
    priority if (!have_r) begin
      take = 1'b1;
    end else if (policy_r == POL_LRU) begin
      take = last_r < best_t_r;
    end else if (policy_r == POL_LFU) begin
      take = (freq_r < best_f_r) || lfu_tie;
    end else begin
      take = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_f_r   <= '0;
      best_t_r   <= '0;
      best_pos_r <= '0;
      have_r     <= 1'b0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.eval && mode_r == MODE_SAMPLE) begin
      if (cnt_r >= CNT_W'(SAMPLE_LIMIT)) begin
        ovf_r <= 1'b1;
      end else begin
        if (take) begin
          best_f_r   <= freq_r;
          best_t_r   <= last_r;
          best_pos_r <= POS_W'(cnt_r);
        end
        have_r <= 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
    end else if (cmd.out_load && mode_r == MODE_SAMPLE && fin_r) begin
      best_f_r   <= '0;
      best_t_r   <= '0;
      best_pos_r <= '0;
      have_r     <= 1'b0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
    end
  end

  // Period count is found by repeated addition of the interval, at most eight steps.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      diff_r <= now_r - last_r;
      acc_r  <= ACC_W'(interval_r);
      per_r  <= '0;
    end else if (cmd.decay_step) begin
      acc_r <= acc_r + ACC_W'(interval_r);
      per_r <= per_r + 1'b1;
    end
  end

  assign fd    = (per_r >= MAX_PERIODS) ? '0 : (freq_r >> per_r);
  assign mul_k = MULK_W'(fd) * MULK_W'(LOG_FACTOR) + MULK_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      fd_r   <= fd;
      prod_r <= PROD_W'(rnd_r) * PROD_W'(mul_k);
    end
    if (cmd.inc) begin
      nf_r <= (fd_r != FREQ_MAX && prod_r[PROD_W-1:RAND_W] == '0) ? fd_r + 1'b1 : fd_r;
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  assign rem_sh = {rem_r, div_r[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      div_r <= rnd_r;
      rem_r <= '0;
      bit_r <= BIT_W'(RAND_W - 1);
    end else if (cmd.mod_step) begin
      div_r <= div_r << 1;
      bit_r <= bit_r - 1'b1;
      if (rem_sh >= {1'b0, cnt_r}) begin
        rem_r <= CNT_W'(rem_sh - {1'b0, cnt_r});
      end else begin
        rem_r <= CNT_W'(rem_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.new_frequency   <= freq_r;
      out_ch.new_last_access <= last_r;
      out_ch.victim_valid    <= 1'b0;
      out_ch.victim_index    <= '0;
      out_ch.no_victim       <= 1'b0;
      out_ch.sample_overflow <= 1'b0;
      unique case (mode_r)
        MODE_TOUCH: begin
          if (policy_r == POL_LFU) begin
            out_ch.new_frequency <= nf_r;
          end
          out_ch.new_last_access <= now_r;
        end
        MODE_INSERT: begin
          if (policy_r == POL_LRU) begin
            out_ch.new_frequency <= LRU_INSERT_FREQ;
          end else if (policy_r == POL_LFU) begin
            out_ch.new_frequency <= LFU_INSERT_FREQ;
          end
          out_ch.new_last_access <= now_r;
        end
        MODE_SAMPLE: begin
          out_ch.sample_overflow <= ovf_r;
          if (fin_r) begin
            out_ch.victim_valid <= 1'b1;
            unique case (policy_r)
              POL_NONE:   out_ch.no_victim <= 1'b1;
              POL_RANDOM: begin
                if (cnt_r > CNT_W'(1)) begin
                  out_ch.victim_index <= POS_W'(rem_r);
                end
              end
              default:    out_ch.victim_index <= best_pos_r;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;

  assign status.lfu_touch    = (mode_r == MODE_TOUCH) && (policy_r == POL_LFU);
  assign status.decay_on     = (interval_r != '0) && (last_r != '0) && (now_r > last_r);
  assign status.decay_more   = (per_r != MAX_PERIODS) && (diff_r >= TIME_W'(acc_r));
  assign status.random_final = (mode_r == MODE_SAMPLE) && fin_r && (policy_r == POL_RANDOM);
  assign status.mod_last     = (bit_r == '0);
  assign status.out_busy     = out_valid_r && !out_ch.ready;

endmodule
